// File: hdl/stm_pkg.sv
`default_nettype none
package stm_pkg;

  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;
  localparam logic [26:0] CENTIHZ_SCALE = 27'd100000000;

  localparam logic [1:0] CFG_PERIOD = 2'd0;
  localparam logic [1:0] CFG_MAX_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_WINDOW = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture input beat, rebuild trigger
    logic calc;       // compute elapsed and latencies
    logic div_start;  // start a division
    logic div_sel;    // 0: missed-count divide, 1: rate divide
    logic mul_step;   // one partial product of completed * scale
    logic miss_save;  // hold the missed-count quotient
    logic update;     // commit state and build result
    logic out_take;   // result taken downstream
  } stm_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_busy;
    logic need_missed;
    logic need_rate;
    logic mul_done;
  } stm_sts_t;

endpackage
`default_nettype wire

// File: hdl/stm_divider.sv
`default_nettype none
module stm_divider
  import stm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             busy,
  output logic [63:0]      quotient
);

  logic [63:0] quot_r, quot_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [64:0] trial;

  // shift-subtract restoring division, one quotient bit per cycle
  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, quot_r[63]} - {1'b0, dvs_r};
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt  = trial[63:0];
        quot_nxt = {quot_r[62:0], 1'b1};
      end else begin
        rem_nxt  = {rem_r[62:0], quot_r[63]};
        quot_nxt = {quot_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quot_r;

endmodule
`default_nettype wire

// File: hdl/stm_datapath.sv
`default_nettype none
module stm_datapath
  import stm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire stm_cmd_t    cmd,
  output stm_sts_t         sts,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [26:0] cfg_data,
  input  wire logic [31:0] in_trigger_low,
  input  wire logic [62:0] in_read_start_us,
  input  wire logic        in_read_ok,
  input  wire logic [62:0] in_read_done_us,
  input  wire logic [62:0] in_pipeline_done_us,
  output logic [19:0]      out_interval_us,
  output logic [31:0]      out_missed_total,
  output logic [31:0]      out_read_error_total,
  output logic             out_report_valid,
  output logic [31:0]      out_rate_centihz,
  output logic [31:0]      out_min_period_out,
  output logic [31:0]      out_max_period_out,
  output logic [31:0]      out_max_read_latency_out,
  output logic [31:0]      out_max_pipeline_latency_out
);

  // configuration
  logic [15:0] period_cfg_r;
  logic [19:0] maxint_cfg_r;
  logic [26:0] window_cfg_r;

  // persistent state
  logic        have_prev_r;
  logic [63:0] prev_trig_r;
  logic [63:0] win_start_r;
  logic [31:0] win_samples_r;
  logic [31:0] min_per_r, max_per_r;
  logic [31:0] missed_r, rd_err_r;
  logic [31:0] max_rd_lat_r, max_pp_lat_r;

  // per-beat working registers
  logic [63:0] trig_r, rdone_r, pdone_r;
  logic        ok_r;
  logic [16:0] p_r;
  logic [63:0] el_r, welap_r;
  logic        el_pos_r, close_r;
  logic [31:0] rd_lat_r, pp_lat_r;
  logic [63:0] prod_r;
  logic [31:0] mul_a_r;
  logic [1:0]  mul_cnt_r;
  logic [31:0] miss_q_r;

  // output registers
  logic [19:0] o_int_r;
  logic [31:0] o_miss_r, o_err_r, o_rate_r, o_min_r, o_max_r, o_rdl_r, o_ppl_r;
  logic        o_rep_r;

  logic        div_busy;
  logic [63:0] div_q;
  logic [63:0] div_dvd, div_dvs;
  logic [63:0] start64, el_c, dr_c, dp_c, welap_c;
  logic [31:0] completed;

  function automatic logic [31:0] sat_lat(input logic [63:0] d);
    logic [31:0] r;
    if (d == '0 || d[63]) r = '0;
    else if (d[63:32] != '0) r = ALL32;
    else r = d[31:0];
    return r;
  endfunction

  assign start64   = {1'b0, in_read_start_us};
  assign el_c      = trig_r - prev_trig_r;
  assign dr_c      = rdone_r - trig_r;
  assign dp_c      = pdone_r - trig_r;
  assign welap_c   = trig_r - (have_prev_r ? win_start_r : trig_r);
  // samples in the window after this beat, minus one; a wrapped count gives zero
  assign completed = (win_samples_r == ALL32) ? '0 : win_samples_r;

  // divider operands: missed = (el + p/2) / p, rate = product / elapsed
  assign div_dvd = cmd.div_sel ? prod_r : (el_r + {48'd0, p_r[16:1]});
  assign div_dvs = cmd.div_sel ? welap_r : {47'd0, p_r};

  stm_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .busy    (div_busy),
    .quotient(div_q)
  );

  assign sts.div_busy    = div_busy;
  assign sts.need_missed = have_prev_r && el_pos_r &&
                           (el_r > ({47'd0, p_r} + {48'd0, p_r[16:1]}));
  assign sts.need_rate   = close_r && (welap_r != '0);
  assign sts.mul_done    = (mul_cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_cfg_r <= 16'd2500;
      maxint_cfg_r <= 20'd50000;
      window_cfg_r <= 27'd1000000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERIOD:       period_cfg_r <= cfg_data[15:0];
        CFG_MAX_INTERVAL: maxint_cfg_r <= cfg_data[19:0];
        CFG_WINDOW:       window_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture beat and work registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      trig_r  <= start64 - {32'd0, (in_read_start_us[31:0] - in_trigger_low)};
      rdone_r <= {1'b0, in_read_done_us};
      pdone_r <= {1'b0, in_pipeline_done_us};
      ok_r    <= in_read_ok;
      p_r     <= (period_cfg_r == '0) ? 17'd1 : {1'b0, period_cfg_r};
    end
    if (cmd.calc) begin
      el_r     <= el_c;
      el_pos_r <= (el_c != '0) && !el_c[63];
      welap_r  <= welap_c;
      close_r  <= !welap_c[63] && (welap_c >= {37'd0, window_cfg_r});
      rd_lat_r <= sat_lat(dr_c);
      pp_lat_r <= sat_lat(dp_c);
      mul_a_r  <= completed;
      prod_r   <= '0;
    end
    // completed * 1e8 in two partial products, 32x14 and 32x13 bits
    if (cmd.mul_step) begin
      if (mul_cnt_r == 2'd2) begin
        prod_r <= {32'd0, mul_a_r} * {50'd0, CENTIHZ_SCALE[13:0]};
      end else if (mul_cnt_r == 2'd1) begin
        prod_r <= prod_r + (({32'd0, mul_a_r} * {51'd0, CENTIHZ_SCALE[26:14]}) << 14);
      end
    end
    // hold the missed quotient before the divider is reused
    if (cmd.miss_save) begin
      miss_q_r <= div_q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_cnt_r <= '0;
    end else if (cmd.calc) begin
      mul_cnt_r <= 2'd2;
    end else if (cmd.mul_step && mul_cnt_r != 2'd0) begin
      mul_cnt_r <= mul_cnt_r - 2'd1;
    end
  end

  // commit state and form the result
  always_ff @(posedge clk) begin
    logic [31:0] mn, mx, rdl, ppl, ms;
    logic [63:0] rate;
    if (!rst_n) begin
      have_prev_r   <= 1'b0;
      prev_trig_r   <= '0;
      win_start_r   <= '0;
      win_samples_r <= '0;
      min_per_r     <= ALL32;
      max_per_r     <= '0;
      missed_r      <= '0;
      rd_err_r      <= '0;
      max_rd_lat_r  <= '0;
      max_pp_lat_r  <= '0;
      o_int_r       <= '0;
      o_miss_r      <= '0;
      o_err_r       <= '0;
      o_rep_r       <= 1'b0;
      o_rate_r      <= '0;
      o_min_r       <= '0;
      o_max_r       <= '0;
      o_rdl_r       <= '0;
      o_ppl_r       <= '0;
    end else if (cmd.update) begin
      mn  = min_per_r;
      mx  = max_per_r;
      ms  = missed_r;
      rdl = max_rd_lat_r;
      ppl = max_pp_lat_r;
      if (have_prev_r && el_pos_r) begin
        if (sts.need_missed) ms = missed_r + miss_q_r - 32'd1;
        if (el_r[63:32] == '0) begin
          if (el_r[31:0] < mn) mn = el_r[31:0];
          if (el_r[31:0] > mx) mx = el_r[31:0];
        end
      end
      if (ok_r && rd_lat_r > rdl) rdl = rd_lat_r;
      if (pp_lat_r > ppl) ppl = pp_lat_r;
      if (welap_r == '0) rate = (mul_a_r != '0) ? {32'd0, ALL32} : '0;
      else rate = div_q;

      o_int_r  <= (have_prev_r && el_pos_r && el_r <= {44'd0, maxint_cfg_r})
                  ? el_r[19:0] : {3'd0, p_r};
      o_miss_r <= ms;
      o_err_r  <= ok_r ? rd_err_r : rd_err_r + 32'd1;
      o_rep_r  <= close_r;
      o_rate_r <= close_r ? ((rate[63:32] != '0) ? ALL32 : rate[31:0]) : '0;
      o_min_r  <= close_r ? ((mn == ALL32) ? '0 : mn) : '0;
      o_max_r  <= close_r ? mx : '0;
      o_rdl_r  <= close_r ? rdl : '0;
      o_ppl_r  <= close_r ? ppl : '0;

      have_prev_r <= 1'b1;
      prev_trig_r <= trig_r;
      missed_r    <= ms;
      rd_err_r    <= ok_r ? rd_err_r : rd_err_r + 32'd1;
      if (close_r) begin
        win_start_r   <= trig_r;
        win_samples_r <= 32'd1;
        min_per_r     <= ALL32;
        max_per_r     <= '0;
        max_rd_lat_r  <= '0;
        max_pp_lat_r  <= '0;
      end else begin
        if (!have_prev_r) win_start_r <= trig_r;
        win_samples_r <= win_samples_r + 32'd1;
        min_per_r     <= mn;
        max_per_r     <= mx;
        max_rd_lat_r  <= rdl;
        max_pp_lat_r  <= ppl;
      end
    end
  end

  assign out_interval_us              = o_int_r;
  assign out_missed_total             = o_miss_r;
  assign out_read_error_total         = o_err_r;
  assign out_report_valid             = o_rep_r;
  assign out_rate_centihz             = o_rate_r;
  assign out_min_period_out           = o_min_r;
  assign out_max_period_out           = o_max_r;
  assign out_max_read_latency_out     = o_rdl_r;
  assign out_max_pipeline_latency_out = o_ppl_r;

  // no report fields without a closed window
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_report_valid |-> (out_rate_centihz == '0 && out_max_period_out == '0))
    else $error("report fields set without report");
  // a window reset leaves min period at all ones
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.update) && $past(close_r) |-> min_per_r == ALL32)
    else $error("window not restarted");
  // interval never zero once a result is formed
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.update) |-> out_interval_us != '0)
    else $error("zero interval");

endmodule
`default_nettype wire

// File: hdl/stm_ctrl.sv
`default_nettype none
module stm_ctrl
  import stm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire stm_sts_t sts,
  output stm_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CALC  = 3'd1;
  localparam logic [2:0] ST_MISS  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_RATE  = 3'd4;
  localparam logic [2:0] ST_WAIT  = 3'd5;
  localparam logic [2:0] ST_COMMIT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       acc;

  // accept while idle, even if the previous result still waits
  assign in_ready  = (state_r == ST_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    cmd.out_take = ov_r && out_ready;
    if (cmd.out_take) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = acc;
        if (acc) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_MISS;
      end
      ST_MISS: begin
        cmd.mul_step = 1'b1;
        if (sts.need_missed) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_MUL;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (!sts.div_busy && sts.mul_done) state_nxt = ST_RATE;
      end
      ST_RATE: begin
        // hold the missed quotient, then reuse the divider for the rate
        cmd.miss_save = 1'b1;
        cmd.div_sel   = 1'b1;
        if (sts.need_rate) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_WAIT;
        end else begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_WAIT: begin
        cmd.div_sel = 1'b1;
        if (!sts.div_busy) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!ov_r || out_ready) begin
          cmd.update = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (!ov_r || out_ready))
    else $error("result overwritten");
  assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> state_r == ST_CALC)
    else $error("beat not started");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid)
    else $error("result lost");

endmodule
`default_nettype wire

// File: hdl/sample_timing_monitor_core.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid/in_ready    | trigger, read start/done, ok, pipeline done
// out     | output    | out_valid/out_ready  | interval, totals, window report
// cfg     | input     | cfg_we, cfg_index    | cfg_data (27 bits)
// Each beat runs the missed-sample divide and the rate divide only when they
// are needed, and no new beat is taken until the last one commits; a 64-step
// shift-subtract divider serves both, one after the other.
// Reset is synchronous on rst_n; configuration returns to its defaults.
// A result waits in the output register; a new beat is taken meanwhile, and
// the commit stalls while the previous result is still not taken.
`default_nettype none
module sample_timing_monitor_core
  import stm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_trigger_low,
  input  wire logic [62:0] in_read_start_us,
  input  wire logic        in_read_ok,
  input  wire logic [62:0] in_read_done_us,
  input  wire logic [62:0] in_pipeline_done_us,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [19:0]      out_interval_us,
  output logic [31:0]      out_missed_total,
  output logic [31:0]      out_read_error_total,
  output logic             out_report_valid,
  output logic [31:0]      out_rate_centihz,
  output logic [31:0]      out_min_period_out,
  output logic [31:0]      out_max_period_out,
  output logic [31:0]      out_max_read_latency_out,
  output logic [31:0]      out_max_pipeline_latency_out,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [26:0] cfg_data
);

  stm_cmd_t cmd;
  stm_sts_t sts;

  stm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stm_datapath u_dp (
    .clk                         (clk),
    .rst_n                       (rst_n),
    .cmd                         (cmd),
    .sts                         (sts),
    .cfg_we                      (cfg_we),
    .cfg_index                   (cfg_index),
    .cfg_data                    (cfg_data),
    .in_trigger_low              (in_trigger_low),
    .in_read_start_us            (in_read_start_us),
    .in_read_ok                  (in_read_ok),
    .in_read_done_us             (in_read_done_us),
    .in_pipeline_done_us         (in_pipeline_done_us),
    .out_interval_us             (out_interval_us),
    .out_missed_total            (out_missed_total),
    .out_read_error_total        (out_read_error_total),
    .out_report_valid            (out_report_valid),
    .out_rate_centihz            (out_rate_centihz),
    .out_min_period_out          (out_min_period_out),
    .out_max_period_out          (out_max_period_out),
    .out_max_read_latency_out    (out_max_read_latency_out),
    .out_max_pipeline_latency_out(out_max_pipeline_latency_out)
  );

endmodule
`default_nettype wire
